/* sv/tfd_pkg.sv */
// Shared widths, frame layout constants and types for the telemetry frame deframer.
package tfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int FRAME_LEN   = 21;
    localparam int ROW_LEN     = FRAME_LEN - 1;
    localparam int COUNT_W     = 5;
    localparam int PAYLOAD_LEN = 11;

    // Frame positions
    localparam int POS_TYPE    = 4;
    localparam int POS_PAYLOAD = 5;
    localparam int POS_TRAIL   = 18;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] TYPE_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] TRAIL_E   = 8'h45;
    localparam logic [BYTE_W-1:0] TRAIL_N   = 8'h4E;
    localparam logic [BYTE_W-1:0] TRAIL_D   = 8'h44;

    localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(FRAME_LEN - 1);

    typedef logic [BYTE_W-1:0]                 t_byte;
    typedef logic [ROW_LEN-1:0][BYTE_W-1:0]     t_row;
    typedef logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] t_payload;
    typedef logic [COUNT_W-1:0]                t_count;

endpackage

/* sv/tfd_if.sv */
// Valid/ready channel interfaces for received bytes and checked frames.
interface tfd_rx_if
    import tfd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfd_res_if
    import tfd_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  frame_ok;
    t_byte range_one;
    t_byte range_two;
    t_byte range_three;
    t_byte range_four;
    t_byte range_five;
    t_byte status_one;
    t_byte status_two;
    t_byte reread_bit_errors;
    t_byte reread_total_errors;
    t_byte write_status;
    t_byte device_status;

    modport source (
        output valid, output frame_ok,
        output range_one, output range_two, output range_three,
        output range_four, output range_five,
        output status_one, output status_two,
        output reread_bit_errors, output reread_total_errors,
        output write_status, output device_status,
        input  ready
    );
    modport sink (
        input  valid, input frame_ok,
        input  range_one, input range_two, input range_three,
        input  range_four, input range_five,
        input  status_one, input status_two,
        input  reread_bit_errors, input reread_total_errors,
        input  write_status, input device_status,
        output ready
    );
endinterface

/* sv/tfd_cell.sv */
// One byte cell of the frame row: loads its neighbor's byte on each shift.
module tfd_cell
    import tfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_byte i_d,
    output t_byte o_q
);

    t_byte r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

/* sv/tfd_row.sv */
// Row of byte cells holding the most recent bytes, newest in cell 0.
module tfd_row
    import tfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_byte i_rx_byte,
    output t_row  o_row
);

    genvar k;
    generate
        for (k = 0; k < ROW_LEN; k++) begin : g_cell
            if (k == 0) begin : g_head
                tfd_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(i_shift),
                    .i_d    (i_rx_byte),
                    .o_q    (o_row[k])
                );
            end else begin : g_link
                tfd_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(i_shift),
                    .i_d    (o_row[k-1]),
                    .o_q    (o_row[k])
                );
            end
        end
    endgenerate

endmodule

/* sv/telemetry_frame_deframer_core.sv */
// Top level of the telemetry frame deframer: byte row, count and result register.
//
//   channel  dir  transaction   payload
//   i_rx     in   one byte      rx_byte
//   o_res    out  one frame     frame_ok + eleven payload bytes
//
// One byte is taken every cycle while i_rx is ready; the row shifts and the check runs on the
// byte that completes the frame, so a result appears the cycle after it.
// A result waits in the output register; i_rx stays ready while that
// register is empty or being taken in the same cycle.
// Synchronous active-low reset clears the byte count and the result valid.
module telemetry_frame_deframer_core
    import tfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfd_rx_if.sink    i_rx,
    tfd_res_if.source o_res
);

    t_row     w_row;
    logic     w_accept;
    logic     w_hunt_drop;
    logic     w_last;
    logic     w_ok;
    t_payload w_payload;

    t_count   r_byte_count, n_byte_count;
    logic     r_res_valid, n_res_valid;
    logic     r_frame_ok;
    t_payload r_payload;

    assign i_rx.ready = !r_res_valid || o_res.ready;
    assign w_accept   = i_rx.valid && i_rx.ready;

    tfd_row u_row (
        .i_clk    (i_clk),
        .i_shift  (w_accept),
        .i_rx_byte(i_rx.rx_byte),
        .o_row    (w_row)
    );

    // Frame byte j (j < 20) sits in cell 19-j; byte 20 is the incoming byte.
    assign w_hunt_drop = (r_byte_count == COUNT_ONE)
                      && !(w_row[0] == SYNC_BYTE && i_rx.rx_byte == SYNC_BYTE);
    assign w_last      = (r_byte_count == COUNT_LAST);

    assign w_ok = w_row[ROW_LEN-1] == SYNC_BYTE
               && w_row[ROW_LEN-2] == SYNC_BYTE
               && w_row[ROW_LEN-1-POS_TYPE] == TYPE_BYTE
               && w_row[ROW_LEN-1-POS_TRAIL] == TRAIL_E
               && w_row[ROW_LEN-2-POS_TRAIL] == TRAIL_N
               && i_rx.rx_byte == TRAIL_D;

    always_comb begin
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            w_payload[i] = w_ok ? w_row[ROW_LEN-1-POS_PAYLOAD-i] : '0;
        end
    end

    always_comb begin
        n_byte_count = r_byte_count;
        if (w_accept) begin
            if (w_hunt_drop) begin
                n_byte_count = COUNT_ONE;
            end else if (w_last) begin
                n_byte_count = '0;
            end else begin
                n_byte_count = r_byte_count + COUNT_ONE;
            end
        end
    end

    always_comb begin
        n_res_valid = r_res_valid;
        if (o_res.ready) begin
            n_res_valid = 1'b0;
        end
        if (w_accept && w_last) begin
            n_res_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_byte_count <= n_byte_count;
            r_res_valid  <= n_res_valid;
        end
    end

    // Load the result on the byte that completes the frame.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_frame_ok <= w_ok;
            r_payload  <= w_payload;
        end
    end

    assign o_res.valid               = r_res_valid;
    assign o_res.frame_ok            = r_frame_ok;
    assign o_res.range_one           = r_payload[0];
    assign o_res.range_two           = r_payload[1];
    assign o_res.range_three         = r_payload[2];
    assign o_res.range_four          = r_payload[3];
    assign o_res.range_five          = r_payload[4];
    assign o_res.status_one          = r_payload[5];
    assign o_res.status_two          = r_payload[6];
    assign o_res.reread_bit_errors   = r_payload[7];
    assign o_res.reread_total_errors = r_payload[8];
    assign o_res.write_status        = r_payload[9];
    assign o_res.device_status       = r_payload[10];

endmodule

/* tb/telemetry_frame_deframer_core_test.sv */
// Self-checking testbench for the telemetry frame deframer core.
`timescale 1ns / 100ps

module telemetry_frame_deframer_core_test;
    import tfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 390;
    localparam int NUM_PHASES     = 5;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum int {DEF_NONE, DEF_SYNC, DEF_TYPE, DEF_TRAIL} t_frame_defect;

    typedef struct packed {
        logic     ok;
        t_payload payload;
    } t_frame_check;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tfd_rx_if  rx_ch ();
    tfd_res_if res_ch ();

    telemetry_frame_deframer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    always #6 i_clk = ~i_clk;

    // Predicted deframer state
    t_count held_count = '0;
    t_byte  held_bytes [FRAME_LEN];

    t_byte        byte_queue [$];
    t_frame_check pending_frames [$];

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int idle_cycles    = 0;
    int bytes_sent     = 0;
    int frames_seen    = 0;
    int frames_passed  = 0;
    int fail_count     = 0;

    string payload_name [PAYLOAD_LEN] = '{
        "range_one", "range_two", "range_three", "range_four", "range_five",
        "status_one", "status_two", "reread_bit_errors", "reread_total_errors",
        "write_status", "device_status"
    };

    // Advance the predicted deframer by one received byte.
    task automatic deframe_byte(input t_byte b);
        t_frame_check done;
        if (held_count < FRAME_LEN) held_bytes[held_count] = b;
        held_count = held_count + COUNT_ONE;
        if (held_count == 2 &&
            (held_bytes[0] != SYNC_BYTE || held_bytes[1] != SYNC_BYTE)) begin
            // drop the older byte and keep hunting
            held_bytes[0] = held_bytes[1];
            held_count = COUNT_ONE;
        end else if (held_count >= FRAME_LEN) begin
            done.ok = held_bytes[0] == SYNC_BYTE && held_bytes[1] == SYNC_BYTE
                && held_bytes[POS_TYPE] == TYPE_BYTE
                && held_bytes[POS_TRAIL] == TRAIL_E
                && held_bytes[POS_TRAIL+1] == TRAIL_N
                && held_bytes[POS_TRAIL+2] == TRAIL_D;
            for (int i = 0; i < PAYLOAD_LEN; i++)
                done.payload[i] = done.ok ? held_bytes[POS_PAYLOAD+i] : '0;
            pending_frames.push_back(done);
            held_count = '0;
        end
    endtask

    task automatic queue_frame(input t_frame_defect defect, input t_payload fill);
        t_byte frame_bytes [FRAME_LEN];
        for (int i = 0; i < FRAME_LEN; i++) frame_bytes[i] = t_byte'($urandom);
        frame_bytes[0] = SYNC_BYTE;
        frame_bytes[1] = SYNC_BYTE;
        frame_bytes[POS_TYPE] = TYPE_BYTE;
        for (int i = 0; i < PAYLOAD_LEN; i++) frame_bytes[POS_PAYLOAD+i] = fill[i];
        frame_bytes[POS_TRAIL]   = TRAIL_E;
        frame_bytes[POS_TRAIL+1] = TRAIL_N;
        frame_bytes[POS_TRAIL+2] = TRAIL_D;
        case (defect)
            DEF_SYNC: begin
                frame_bytes[$urandom_range(1)] ^= t_byte'($urandom_range(1, 255));
            end
            DEF_TYPE: begin
                frame_bytes[POS_TYPE] ^= t_byte'($urandom_range(1, 255));
            end
            DEF_TRAIL: begin
                frame_bytes[POS_TRAIL + $urandom_range(2)] ^= t_byte'($urandom_range(1, 255));
            end
            default: ;
        endcase
        foreach (frame_bytes[i]) byte_queue.push_back(frame_bytes[i]);
    endtask

    // Sender: predict on each accepted transaction, then present the next byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                deframe_byte(rx_ch.rx_byte);
                bytes_sent++;
            end
            if (!rx_ch.valid || rx_ch.ready) begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    rx_ch.rx_byte <= byte_queue.pop_front();
                    rx_ch.valid   <= 1'b1;
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted frame against the oldest prediction.
    always @(posedge i_clk) begin : frame_monitor
        t_frame_check want;
        t_payload     got;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = {res_ch.device_status, res_ch.write_status,
                       res_ch.reread_total_errors, res_ch.reread_bit_errors,
                       res_ch.status_two, res_ch.status_one, res_ch.range_five,
                       res_ch.range_four, res_ch.range_three, res_ch.range_two,
                       res_ch.range_one};
                frames_seen++;
                if (pending_frames.size() == 0) begin
                    $error("frame result with no frame pending");
                    fail_count++;
                end else begin
                    want = pending_frames.pop_front();
                    if (want.ok) frames_passed++;
                    if (res_ch.frame_ok !== want.ok) begin
                        $error("frame_ok: expected %0d, got %0d", want.ok, res_ch.frame_ok);
                        fail_count++;
                    end
                    for (int i = 0; i < PAYLOAD_LEN; i++) begin
                        if (got[i] !== want.payload[i]) begin
                            $error("%s: expected 0x%02h, got 0x%02h",
                                   payload_name[i], want.payload[i], got[i]);
                            fail_count++;
                        end
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int       send_pct [NUM_PHASES];
        int       hold_pct [NUM_PHASES];
        int       phase_start;
        int       pick;
        t_payload fill;

        send_pct = '{0, 84, 0, 18, 0};
        hold_pct = '{0, 0, 84, 18, 0};

        i_rst_n      = 1'b0;
        rx_ch.valid  = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: hunt past junk and a lone sync byte, then one clean frame
        // whose payload swings between the byte extremes.
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(SYNC_BYTE);
        byte_queue.push_back(TYPE_BYTE);
        for (int i = 0; i < PAYLOAD_LEN; i++) fill[i] = i[0] ? 8'hFF : 8'h00;
        queue_frame(DEF_NONE, fill);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // hold off until the pipe has drained
            while (byte_queue.size() > 0 || rx_ch.valid || pending_frames.size() > 0)
                @(negedge i_clk);
            send_idle_pct = send_pct[p];
            stall_pct     = hold_pct[p];
            phase_start   = byte_queue.size();
            while (byte_queue.size() - phase_start < PHASE_BYTES) begin
                pick = $urandom_range(99);
                for (int i = 0; i < PAYLOAD_LEN; i++) fill[i] = t_byte'($urandom);
                if (pick < 4) fill = '0;
                else if (pick < 8) fill = '1;
                if (pick < 70) begin
                    queue_frame(DEF_NONE, fill);
                end else if (pick < 80) begin
                    queue_frame(DEF_TYPE, fill);
                end else if (pick < 88) begin
                    queue_frame(DEF_TRAIL, fill);
                end else if (pick < 93) begin
                    queue_frame(DEF_SYNC, fill);
                end else begin
                    repeat ($urandom_range(1, 6))
                        byte_queue.push_back(($urandom_range(3) == 0) ? SYNC_BYTE
                                                                       : t_byte'($urandom));
                end
            end
        end

        while (byte_queue.size() > 0 || rx_ch.valid || pending_frames.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("summary: %0d bytes sent over %0d flow-control phases", bytes_sent, NUM_PHASES);
        $display("summary: %0d frames checked, %0d passed, %0d failed",
                 frames_seen, frames_passed, frames_seen - frames_passed);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* telemetry_frame_deframer_core.f */
sv/tfd_pkg.sv
sv/tfd_if.sv
sv/tfd_cell.sv
sv/tfd_row.sv
sv/telemetry_frame_deframer_core.sv
tb/telemetry_frame_deframer_core_test.sv
